// ===== rtl/core/one_wire_bus_master_top_defines.svh =====
// ----------------------------------------------------------------------------
// one_wire_bus_master_top_defines: assertion helpers for the 1-Wire bus master
// Every check is sampled on aclk and is held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef ONE_WIRE_BUS_MASTER_TOP_DEFINES_SVH
`define ONE_WIRE_BUS_MASTER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OWM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OWM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/owm_pkg.sv =====
// ----------------------------------------------------------------------------
// owm_pkg: shared types and timing for the 1-Wire bus master
// Holds the op and phase codes, the state and result structs and the
// per-phase tick counts.
// ----------------------------------------------------------------------------
package owm_pkg;

    // Bus timing in microsecond ticks
    localparam int RESET_TICKS       = 500;
    localparam int SHORT_LOW_TICKS   = 5;
    localparam int SLOT_TICKS        = 60;
    localparam int READ_SAMPLE_TICKS = 5;
    localparam int READ_TAIL_TICKS   = 50;

    localparam int TICK_W = 10;
    localparam int BITS_W = 4;
    localparam logic [BITS_W-1:0] BITS_PER_BYTE = 4'd8;

    // Down-counter load value for a phase: length minus one, zero length as one
    function automatic logic [TICK_W-1:0] span(input int ticks);
        logic [TICK_W-1:0] t;
        t = (ticks == 0) ? '0 : TICK_W'(ticks - 1);
        return t;
    endfunction

    localparam logic [TICK_W-1:0] RESET_SPAN     = span(RESET_TICKS);
    localparam logic [TICK_W-1:0] SHORT_LOW_SPAN = span(SHORT_LOW_TICKS);
    localparam logic [TICK_W-1:0] SLOT_SPAN      = span(SLOT_TICKS);
    localparam logic [TICK_W-1:0] RD_SAMPLE_SPAN = span(READ_SAMPLE_TICKS);
    localparam logic [TICK_W-1:0] RD_TAIL_SPAN   = span(READ_TAIL_TICKS);

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_RESET = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_RST_LOW = 3'd1,
        PH_RST_REL = 3'd2,
        PH_BIT_LOW = 3'd3,
        PH_BIT_REL = 3'd4,
        PH_RECOVER = 3'd5,
        PH_RD_WAIT = 3'd6,
        PH_RD_TAIL = 3'd7
    } phase_t;

    typedef struct packed {
        phase_t              phase;
        op_t                 kind;
        logic [TICK_W-1:0]   tick_count;
        logic [BITS_W-1:0]   bits_left;
        logic [7:0]          shift_byte;
    } owm_state_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       refused;
    } owm_result_t;

    // Low time of a new bit slot: a written zero holds the line for a full slot
    function automatic logic [TICK_W-1:0] bit_low_span(input op_t kind,
                                                       input logic [7:0] sb);
        logic [TICK_W-1:0] t;
        t = (kind == OP_WRITE && !sb[0]) ? SLOT_SPAN : SHORT_LOW_SPAN;
        return t;
    endfunction

endpackage

// ===== rtl/core/owm_ctrl.sv =====
// ----------------------------------------------------------------------------
// owm_ctrl: bus sequencer for the 1-Wire master
// Holds the phase, tick and bit counters and the shift byte, and works out
// one tick's result and next state from the accepted item.
// ----------------------------------------------------------------------------
module owm_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  logic [1:0]           op,
    input  logic [7:0]           data_byte,
    input  logic                 line_in,
    output owm_pkg::owm_result_t result,
    output logic                 idle
);

    owm_pkg::owm_state_t state_reg;
    owm_pkg::owm_state_t state_next;
    owm_pkg::owm_state_t st;
    logic                finish;
    logic                bit_end;

    // State register, advanced once per accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{phase: owm_pkg::PH_IDLE, kind: owm_pkg::OP_TICK,
                           tick_count: '0, bits_left: '0, shift_byte: '0};
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    assign idle = (state_reg.phase == owm_pkg::PH_IDLE);

    // One tick of the sequencer
    always_comb begin
        st      = state_reg;
        result  = '0;
        finish  = 1'b0;
        bit_end = 1'b0;

        // Command start, or refusal while an operation runs
        if (st.phase == owm_pkg::PH_IDLE) begin
            if (op != owm_pkg::OP_TICK) begin
                st.kind = owm_pkg::op_t'(op);
                if (op == owm_pkg::OP_RESET) begin
                    st.phase      = owm_pkg::PH_RST_LOW;
                    st.tick_count = owm_pkg::RESET_SPAN;
                end else begin
                    st.shift_byte = (op == owm_pkg::OP_WRITE) ? data_byte : 8'h00;
                    st.bits_left  = owm_pkg::BITS_PER_BYTE;
                    st.phase      = owm_pkg::PH_BIT_LOW;
                    st.tick_count = owm_pkg::bit_low_span(st.kind, st.shift_byte);
                end
            end
        end else if (op != owm_pkg::OP_TICK) begin
            result.refused = 1'b1;
        end

        if (st.phase != owm_pkg::PH_IDLE) begin
            result.busy_res  = 1'b1;
            result.drive_low = (st.phase == owm_pkg::PH_RST_LOW) ||
                               (st.phase == owm_pkg::PH_BIT_LOW);

            // Sample the bus on the last tick of the read wait
            if (st.phase == owm_pkg::PH_RD_WAIT && st.tick_count == '0) begin
                st.shift_byte = {line_in, st.shift_byte[7:1]};
            end

            // Count down, or move to the next phase
            if (st.tick_count != '0) begin
                st.tick_count = st.tick_count - 1'b1;
            end else begin
                case (st.phase)
                    owm_pkg::PH_RST_LOW: begin
                        st.phase      = owm_pkg::PH_RST_REL;
                        st.tick_count = owm_pkg::RESET_SPAN;
                    end
                    owm_pkg::PH_RST_REL: begin
                        finish = 1'b1;
                    end
                    owm_pkg::PH_BIT_LOW: begin
                        if (st.kind == owm_pkg::OP_WRITE) begin
                            if (st.shift_byte[0]) begin
                                st.phase      = owm_pkg::PH_BIT_REL;
                                st.tick_count = owm_pkg::SLOT_SPAN;
                            end else begin
                                st.phase      = owm_pkg::PH_RECOVER;
                                st.tick_count = '0;
                            end
                        end else begin
                            st.phase      = owm_pkg::PH_RD_WAIT;
                            st.tick_count = owm_pkg::RD_SAMPLE_SPAN;
                        end
                    end
                    owm_pkg::PH_RD_WAIT: begin
                        st.phase      = owm_pkg::PH_RD_TAIL;
                        st.tick_count = owm_pkg::RD_TAIL_SPAN;
                    end
                    default: begin
                        bit_end = 1'b1;
                    end
                endcase
            end

            // End of a bit slot: next bit or done
            if (bit_end) begin
                if (st.kind == owm_pkg::OP_WRITE) begin
                    st.shift_byte = {1'b0, st.shift_byte[7:1]};
                end
                st.bits_left = st.bits_left - 1'b1;
                if (st.bits_left == '0) begin
                    finish = 1'b1;
                end else begin
                    st.phase      = owm_pkg::PH_BIT_LOW;
                    st.tick_count = owm_pkg::bit_low_span(st.kind, st.shift_byte);
                end
            end

            if (finish) begin
                result.done_res = 1'b1;
                if (st.kind == owm_pkg::OP_READ) begin
                    result.read_byte = st.shift_byte;
                end
                st.phase      = owm_pkg::PH_IDLE;
                st.tick_count = '0;
            end
        end

        state_next = st;
    end

endmodule

// ===== rtl/core/owm_out_reg.sv =====
// ----------------------------------------------------------------------------
// owm_out_reg: result register for the 1-Wire master
// Holds one result item and loads a new one while empty or in the cycle the old one leaves.
// ----------------------------------------------------------------------------
module owm_out_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  owm_pkg::owm_result_t res_in,
    input  logic                 m_ready,
    output logic                 m_valid,
    output logic                 can_load,
    output owm_pkg::owm_result_t res_out
);

    logic                 valid_reg;
    owm_pkg::owm_result_t data_reg;

    // Free when empty or when the held item is taken this cycle
    assign can_load = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res_in;
        end
    end

    assign m_valid = valid_reg;
    assign res_out = data_reg;

endmodule

// ===== rtl/core/one_wire_bus_master_top.sv =====
// ----------------------------------------------------------------------------
// one_wire_bus_master_top: 1-Wire bus master, one item per microsecond tick
// Result: an accepted item's result is registered and shown on the m_ side in the cycle after.
// Throughput: 1 item per cycle while m_ready is high, set by the single result register.
// Reset: synchronous aresetn low returns the sequencer to idle, output empty.
// ----------------------------------------------------------------------------
module one_wire_bus_master_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_op,
    input  logic [7:0] s_data_byte,
    input  logic       s_line_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_drive_low,
    output logic       m_busy_res,
    output logic       m_done_res,
    output logic [7:0] m_read_byte,
    output logic       m_refused
);

    logic                 accept;
    logic                 can_load;
    logic                 idle;
    logic                 busy_cmd;
    owm_pkg::owm_result_t tick_res;
    owm_pkg::owm_result_t out_res;

    assign s_ready = can_load;
    assign accept  = s_valid && can_load;

    // Sequencer
    owm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .op        (s_op),
        .data_byte (s_data_byte),
        .line_in   (s_line_in),
        .result    (tick_res),
        .idle      (idle)
    );

    // Result register
    owm_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .res_in   (tick_res),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .can_load (can_load),
        .res_out  (out_res)
    );

    assign m_drive_low = out_res.drive_low;
    assign m_busy_res  = out_res.busy_res;
    assign m_done_res  = out_res.done_res;
    assign m_read_byte = out_res.read_byte;
    assign m_refused   = out_res.refused;

    // Checks
    assign busy_cmd = accept && !idle && (s_op != owm_pkg::OP_TICK);

`include "one_wire_bus_master_top_defines.svh"

    `OWM_ASSERT_SAME(a_done_busy, m_valid && m_done_res, m_busy_res, "done without busy")
    `OWM_ASSERT_SAME(a_drive_busy, m_valid && m_drive_low, m_busy_res, "drive while not busy")
    `OWM_ASSERT_SAME(a_rb_done, m_valid && (m_read_byte != 8'h00), m_done_res, "stray read byte")
    `OWM_ASSERT_NEXT(a_refuse, busy_cmd, m_valid && m_refused, "busy command not refused")

endmodule

// ===== tb/one_wire_bus_master_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_bus_master_top_test: self-checking bench for the 1-Wire bus master
// Feeds microsecond tick items through the s_ handshake and follows them with
// a cycle-free model of the reset, write and read sequencer. Every result item
// on the m_ side is checked field by field against the model, in order.
// ----------------------------------------------------------------------------
module one_wire_bus_master_top_test;

    localparam int CYCLE_LIMIT = 200000;

    typedef logic [owm_pkg::TICK_W-1:0] tick_t;

    // Down-counter loads: phase length minus one, a zero length runs one tick
    localparam tick_t RST_LEN    = (owm_pkg::RESET_TICKS == 0) ? '0 :
                                   tick_t'(owm_pkg::RESET_TICKS - 1);
    localparam tick_t SHORT_LEN  = (owm_pkg::SHORT_LOW_TICKS == 0) ? '0 :
                                   tick_t'(owm_pkg::SHORT_LOW_TICKS - 1);
    localparam tick_t SLOT_LEN   = (owm_pkg::SLOT_TICKS == 0) ? '0 :
                                   tick_t'(owm_pkg::SLOT_TICKS - 1);
    localparam tick_t SAMPLE_LEN = (owm_pkg::READ_SAMPLE_TICKS == 0) ? '0 :
                                   tick_t'(owm_pkg::READ_SAMPLE_TICKS - 1);
    localparam tick_t TAIL_LEN   = (owm_pkg::READ_TAIL_TICKS == 0) ? '0 :
                                   tick_t'(owm_pkg::READ_TAIL_TICKS - 1);

    typedef struct packed {
        owm_pkg::op_t op;
        logic [7:0]   data;
        logic         line;
        logic         drain;   // hold this item back until every result is in
    } bus_tick_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_op = owm_pkg::OP_TICK;
    logic [7:0] s_data_byte = 8'h00;
    logic       s_line_in = 1'b1;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_drive_low;
    logic       m_busy_res;
    logic       m_done_res;
    logic [7:0] m_read_byte;
    logic       m_refused;

    one_wire_bus_master_top uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_data_byte (s_data_byte),
        .s_line_in   (s_line_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_drive_low (m_drive_low),
        .m_busy_res  (m_busy_res),
        .m_done_res  (m_done_res),
        .m_read_byte (m_read_byte),
        .m_refused   (m_refused)
    );

    bus_tick_t            tick_q[$];
    owm_pkg::owm_result_t result_due_q[$];

    // Model copy of the sequencer state
    owm_pkg::phase_t            bus_phase = owm_pkg::PH_IDLE;
    owm_pkg::op_t               cur_kind = owm_pkg::OP_TICK;
    tick_t                      ticks_left = '0;
    logic [owm_pkg::BITS_W-1:0] bits_rem = '0;
    logic [7:0]                 shreg = 8'h00;

    int errors = 0;
    int cycles = 0;
    int items_sent = 0;
    int results_seen = 0;
    int ops_started[4] = '{0, 0, 0, 0};
    int refusals = 0;

    // Clock
    initial begin
        forever #2 aclk = ~aclk;
    end

    // Cycle limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, result_due_q.size());
            $display("one_wire_bus_master_top_test NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer model
    // ------------------------------------------------------------------------

    // Open a bit slot; a written zero holds the line low for the whole slot
    task automatic open_slot();
        bus_phase = owm_pkg::PH_BIT_LOW;
        ticks_left = (cur_kind == owm_pkg::OP_WRITE && !shreg[0]) ? SLOT_LEN : SHORT_LEN;
    endtask

    task automatic step_bus_master(input owm_pkg::op_t cmd, input logic [7:0] data,
                                   input logic line, output owm_pkg::owm_result_t r);
        logic finish;
        logic bit_end;
        finish = 1'b0;
        bit_end = 1'b0;
        r = '0;

        // Command decode: accepted only when idle
        if (bus_phase == owm_pkg::PH_IDLE) begin
            if (cmd != owm_pkg::OP_TICK) begin
                cur_kind = cmd;
                ops_started[cmd]++;
                if (cmd == owm_pkg::OP_RESET) begin
                    bus_phase = owm_pkg::PH_RST_LOW;
                    ticks_left = RST_LEN;
                end else begin
                    shreg = (cmd == owm_pkg::OP_WRITE) ? data : 8'h00;
                    bits_rem = owm_pkg::BITS_PER_BYTE;
                    open_slot();
                end
            end
        end else if (cmd != owm_pkg::OP_TICK) begin
            r.refused = 1'b1;
        end

        if (bus_phase != owm_pkg::PH_IDLE) begin
            r.busy_res = 1'b1;
            r.drive_low = (bus_phase == owm_pkg::PH_RST_LOW ||
                           bus_phase == owm_pkg::PH_BIT_LOW);
            // Read sample lands on the last tick of the wait phase
            if (bus_phase == owm_pkg::PH_RD_WAIT && ticks_left == '0)
                shreg = {line, shreg[7:1]};

            if (ticks_left != '0) begin
                ticks_left = ticks_left - 1'b1;
            end else begin
                case (bus_phase)
                    owm_pkg::PH_RST_LOW: begin
                        bus_phase = owm_pkg::PH_RST_REL;
                        ticks_left = RST_LEN;
                    end
                    owm_pkg::PH_RST_REL: finish = 1'b1;
                    owm_pkg::PH_BIT_LOW: begin
                        if (cur_kind == owm_pkg::OP_WRITE) begin
                            if (shreg[0]) begin
                                bus_phase = owm_pkg::PH_BIT_REL;
                                ticks_left = SLOT_LEN;
                            end else begin
                                bus_phase = owm_pkg::PH_RECOVER;
                                ticks_left = '0;
                            end
                        end else begin
                            bus_phase = owm_pkg::PH_RD_WAIT;
                            ticks_left = SAMPLE_LEN;
                        end
                    end
                    owm_pkg::PH_RD_WAIT: begin
                        bus_phase = owm_pkg::PH_RD_TAIL;
                        ticks_left = TAIL_LEN;
                    end
                    default: bit_end = 1'b1;
                endcase
            end

            // End of a bit slot: next bit or end of byte
            if (bit_end) begin
                if (cur_kind == owm_pkg::OP_WRITE)
                    shreg = shreg >> 1;
                bits_rem = bits_rem - 1'b1;
                if (bits_rem == '0)
                    finish = 1'b1;
                else
                    open_slot();
            end

            if (finish) begin
                r.done_res = 1'b1;
                if (cur_kind == owm_pkg::OP_READ)
                    r.read_byte = shreg;
                bus_phase = owm_pkg::PH_IDLE;
                ticks_left = '0;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------------

    // line mode: 0 held low, 1 released high, other random
    function automatic logic pick_line(input int mode);
        logic v;
        v = (mode == 0) ? 1'b0 : (mode == 1) ? 1'b1 : 1'($urandom_range(1));
        return v;
    endfunction

    // One command followed by exactly the ticks it needs plus an idle tail.
    // Stray commands fall inside the operation, some right on its done tick.
    task automatic queue_op(input owm_pkg::op_t cmd, input logic [7:0] data,
                            input int line_mode, input int refuse_pct, input int gap,
                            input logic drain);
        int len;
        bus_tick_t t;
        case (cmd)
            owm_pkg::OP_RESET: len = 2 * owm_pkg::RESET_TICKS;
            owm_pkg::OP_READ:  len = 8 * (owm_pkg::SHORT_LOW_TICKS +
                                          owm_pkg::READ_SAMPLE_TICKS +
                                          owm_pkg::READ_TAIL_TICKS);
            default: begin
                len = 0;
                for (int b = 0; b < 8; b++)
                    len += data[b] ? (owm_pkg::SHORT_LOW_TICKS + owm_pkg::SLOT_TICKS)
                                   : (owm_pkg::SLOT_TICKS + 1);
            end
        endcase
        t.op = cmd;
        t.data = data;
        t.line = pick_line(line_mode);
        t.drain = drain;
        tick_q.push_back(t);
        t.drain = 1'b0;
        for (int i = 1; i < len + gap; i++) begin
            t.op = owm_pkg::OP_TICK;
            t.data = 8'($urandom_range(255));
            t.line = pick_line(line_mode);
            if (i < len && ($urandom_range(99) < refuse_pct ||
                            (i == len - 1 && $urandom_range(2) == 0)))
                t.op = owm_pkg::op_t'($urandom_range(3, 1));
            tick_q.push_back(t);
        end
    endtask

    initial begin
        bus_tick_t t;

        // Idle ticks at the field extremes
        for (int i = 0; i < 4; i++) begin
            t.op = owm_pkg::OP_TICK;
            t.data = i[0] ? 8'hFF : 8'h00;
            t.line = i[1];
            t.drain = 1'b0;
            tick_q.push_back(t);
        end
        // Every command once: a write of mixed ones and zeros, then a read
        // started on the tick after the write is done, then a full drain
        queue_op(owm_pkg::OP_RESET, 8'hFF, 2, 3, 1, 1'b0);
        queue_op(owm_pkg::OP_WRITE, 8'h96, 2, 2, 0, 1'b0);
        queue_op(owm_pkg::OP_READ, 8'h00, 2, 2, 3, 1'b1);
        for (int i = 0; i < 4; i++) begin
            t.op = owm_pkg::OP_TICK;
            t.data = 8'($urandom_range(255));
            t.line = 1'($urandom_range(1));
            t.drain = (i == 0);
            tick_q.push_back(t);
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Drain, then let the pipeline settle
        while (tick_q.size() != 0 || s_valid || result_due_q.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("%0d items, %0d results checked: %0d resets, %0d writes, %0d reads",
                 items_sent, results_seen, ops_started[owm_pkg::OP_RESET],
                 ops_started[owm_pkg::OP_WRITE], ops_started[owm_pkg::OP_READ]);
        $display("%0d commands refused while busy, %0d mismatches", refusals, errors);
        if (errors == 0) begin
            $display("one_wire_bus_master_top_test OK");
        end else begin
            $display("one_wire_bus_master_top_test NOT OK");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver: bursts of items with random gaps, model updated on acceptance
    // ------------------------------------------------------------------------
    int tx_left = 0;
    bit tx_idle = 1'b1;

    always @(posedge aclk) begin : drive_items
        owm_pkg::owm_result_t r;
        bus_tick_t t;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                step_bus_master(owm_pkg::op_t'(s_op), s_data_byte, s_line_in, r);
                result_due_q.push_back(r);
                items_sent++;
            end
            if (!s_valid || s_ready) begin
                if (tx_left == 0) begin
                    tx_idle = !tx_idle;
                    if (tx_idle)
                        tx_left = $urandom_range(8, 1);
                    else
                        tx_left = ($urandom_range(7) == 0) ? $urandom_range(600, 200)
                                                           : $urandom_range(40, 1);
                end
                if (tx_idle) begin
                    tx_left--;
                    s_valid <= 1'b0;
                end else if (tick_q.size() != 0 &&
                             !(tick_q[0].drain && result_due_q.size() != 0)) begin
                    t = tick_q.pop_front();
                    tx_left--;
                    s_valid <= 1'b1;
                    s_op <= t.op;
                    s_data_byte <= t.data;
                    s_line_in <= t.line;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: ready runs and stalls, plus one long hold-off
    // ------------------------------------------------------------------------
    int  rx_left = 0;
    bit  rx_stall = 1'b1;
    int  rx_taken = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                rx_taken++;
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && rx_taken >= 600) begin
                hold_done = 1'b1;
                hold_left = 400;
                m_ready <= 1'b0;
            end else begin
                if (rx_left == 0) begin
                    rx_stall = !rx_stall;
                    if (rx_stall)
                        rx_left = $urandom_range(6, 1);
                    else
                        rx_left = ($urandom_range(7) == 0) ? $urandom_range(300, 100)
                                                           : $urandom_range(30, 1);
                end
                rx_left--;
                m_ready <= !rx_stall;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: in-order compare against the model
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= 40)
                $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : check_results
        owm_pkg::owm_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (result_due_q.size() == 0) begin
                errors++;
                if (errors <= 40)
                    $display("%0t: extra result item, expected none, got %b %b %b %0h %b",
                             $realtime, m_drive_low, m_busy_res, m_done_res, m_read_byte,
                             m_refused);
            end else begin
                want = result_due_q.pop_front();
                if (want.refused)
                    refusals++;
                check_field("drive_low", 8'(want.drive_low), 8'(m_drive_low));
                check_field("busy_res", 8'(want.busy_res), 8'(m_busy_res));
                check_field("done_res", 8'(want.done_res), 8'(m_done_res));
                check_field("read_byte", want.read_byte, m_read_byte);
                check_field("refused", 8'(want.refused), 8'(m_refused));
            end
        end
    end

endmodule
